>>> design/rayslab_pkg.sv
// shared types and constants for the 2d ray versus box slab test
// no dependencies
package rayslab_pkg;

  localparam int DIN_W  = 32;
  localparam int DIST_W = 31;
  localparam int NRM_W  = 2;
  localparam int THR_W  = 16;
  localparam int LANES  = 4;

  localparam logic [THR_W-1:0] THR_RESET = 16'd1;

  localparam logic signed [NRM_W-1:0] NRM_NONE = 2'sb00;
  localparam logic signed [NRM_W-1:0] NRM_POS  = 2'sb01;
  localparam logic signed [NRM_W-1:0] NRM_NEG  = 2'sb11;

  // divider lane assignment
  localparam int LN_X_LO = 0;
  localparam int LN_X_HI = 1;
  localparam int LN_Y_LO = 2;
  localparam int LN_Y_HI = 3;

  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             par_x;
    logic             par_y;
    logic             ok_x;
    logic             ok_y;
  } side_t;

endpackage

>>> design/rayslab_if.sv
// valid/ready channel interfaces for ray items and results
// depends on rayslab_pkg
interface rayslab_in_if;
  logic valid;
  logic ready;
  logic signed [rayslab_pkg::DIN_W-1:0] origin_x;
  logic signed [rayslab_pkg::DIN_W-1:0] origin_y;
  logic signed [rayslab_pkg::DIN_W-1:0] dir_x;
  logic signed [rayslab_pkg::DIN_W-1:0] dir_y;
  logic signed [rayslab_pkg::DIN_W-1:0] box_left;
  logic signed [rayslab_pkg::DIN_W-1:0] box_top;
  logic signed [rayslab_pkg::DIN_W-1:0] box_right;
  logic signed [rayslab_pkg::DIN_W-1:0] box_bottom;
  modport source (output valid, origin_x, origin_y, dir_x, dir_y,
                  box_left, box_top, box_right, box_bottom, input ready);
  modport sink (input valid, origin_x, origin_y, dir_x, dir_y,
                box_left, box_top, box_right, box_bottom, output ready);
endinterface

interface rayslab_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [rayslab_pkg::DIST_W-1:0] distance;
  logic signed [rayslab_pkg::NRM_W-1:0] normal_x;
  logic signed [rayslab_pkg::NRM_W-1:0] normal_y;
  modport source (output valid, hit, distance, normal_x, normal_y, input ready);
  modport sink (input valid, hit, distance, normal_x, normal_y, output ready);
endinterface

>>> design/rayslab_div.sv
// pipelined restoring divider, one quotient bit per stage, four lanes
// depends on rayslab_pkg
module rayslab_div #(
  parameter int NW = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [NW-1:0]                       in_dq  [rayslab_pkg::LANES],
  input  logic [rayslab_pkg::DIN_W-1:0]       in_den [rayslab_pkg::LANES],
  input  rayslab_pkg::side_t                  in_side,
  output logic                                out_valid,
  output logic [NW-1:0]                       out_quo [rayslab_pkg::LANES],
  output rayslab_pkg::side_t                  out_side
);

  localparam int RW = rayslab_pkg::DIN_W;
  localparam int LN = rayslab_pkg::LANES;

  logic               v_r    [NW];
  rayslab_pkg::side_t side_r [NW];
  logic [RW-1:0]      rem_r  [NW][LN];
  logic [NW-1:0]      dq_r   [NW][LN];
  logic [RW-1:0]      den_r  [NW][LN];

  logic               v_src    [NW];
  rayslab_pkg::side_t side_src [NW];
  logic [RW-1:0]      rem_src  [NW][LN];
  logic [NW-1:0]      dq_src   [NW][LN];
  logic [RW-1:0]      den_src  [NW][LN];

  logic [RW-1:0]      rem_nxt  [NW][LN];
  logic [NW-1:0]      dq_nxt   [NW][LN];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign v_src[s]    = in_valid;
      assign side_src[s] = in_side;
      for (genvar l = 0; l < LN; l++) begin : g_ln
        assign rem_src[s][l] = '0;
        assign dq_src[s][l]  = in_dq[l];
        assign den_src[s][l] = in_den[l];
      end
    end else begin : g_next
      assign v_src[s]    = v_r[s-1];
      assign side_src[s] = side_r[s-1];
      for (genvar l = 0; l < LN; l++) begin : g_ln
        assign rem_src[s][l] = rem_r[s-1][l];
        assign dq_src[s][l]  = dq_r[s-1][l];
        assign den_src[s][l] = den_r[s-1][l];
      end
    end

    for (genvar l = 0; l < LN; l++) begin : g_step
      logic [RW+1:0] trial;
      logic          ge;
      always_comb begin
        trial = {1'b0, rem_src[s][l], dq_src[s][l][NW-1]} - {2'b00, den_src[s][l]};
        ge    = ~trial[RW+1];
        rem_nxt[s][l] = ge ? trial[RW-1:0] : {rem_src[s][l][RW-2:0], dq_src[s][l][NW-1]};
        dq_nxt[s][l]  = {dq_src[s][l][NW-2:0], ge};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s][l] <= rem_nxt[s][l];
          dq_r[s][l]  <= dq_nxt[s][l];
          den_r[s][l] <= den_src[s][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_src[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_src[s];
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_side  = side_r[NW-1];
  for (genvar l = 0; l < LN; l++) begin : g_out
    assign out_quo[l] = dq_r[NW-1][l];
  end

endmodule

>>> design/ray_aabb_slab_intersection_unit.sv
// 2d ray versus axis-aligned box slab test, fixed point
// one transfer per cycle sustained while the output is accepted
// most of the depth is the four-lane pipelined divider, one quotient bit per stage
// the whole pipeline holds while a result waits at the output register
// synchronous active-low reset clears valid bits and sets the threshold to 1
// depends on rayslab_pkg, rayslab_if, rayslab_div
module ray_aabb_slab_intersection_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rayslab_pkg::THR_W-1:0]        cfg_wdata,
  rayslab_in_if.sink                           in_ray,
  rayslab_out_if.source                        out_res
);

  localparam int DW = rayslab_pkg::DIN_W;
  localparam int LN = rayslab_pkg::LANES;
  localparam int NW = DW + FRAC_BITS;
  localparam int TW = NW + 1;
  localparam logic signed [TW-1:0] T_INF  = {1'b0, {NW{1'b1}}};
  localparam logic signed [TW-1:0] D_MAX  = TW'({rayslab_pkg::DIST_W{1'b1}});

  logic en;
  logic [rayslab_pkg::THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rayslab_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // entry stage
  logic signed [DW:0] diff [LN];
  logic signed [DW-1:0] dir [LN];
  logic [DW-1:0] nmag [LN];
  logic [DW:0] dxm, dym;
  logic par_x, par_y, ok_x, ok_y;
  rayslab_pkg::side_t side_nxt;

  assign dir[rayslab_pkg::LN_X_LO] = in_ray.dir_x;
  assign dir[rayslab_pkg::LN_X_HI] = in_ray.dir_x;
  assign dir[rayslab_pkg::LN_Y_LO] = in_ray.dir_y;
  assign dir[rayslab_pkg::LN_Y_HI] = in_ray.dir_y;
  assign diff[rayslab_pkg::LN_X_LO] = (DW+1)'(in_ray.box_left)   - (DW+1)'(in_ray.origin_x);
  assign diff[rayslab_pkg::LN_X_HI] = (DW+1)'(in_ray.box_right)  - (DW+1)'(in_ray.origin_x);
  assign diff[rayslab_pkg::LN_Y_LO] = (DW+1)'(in_ray.box_top)    - (DW+1)'(in_ray.origin_y);
  assign diff[rayslab_pkg::LN_Y_HI] = (DW+1)'(in_ray.box_bottom) - (DW+1)'(in_ray.origin_y);

  always_comb begin
    logic [DW:0] m;
    for (int l = 0; l < LN; l++) begin
      m = diff[l][DW] ? (DW+1)'(-diff[l]) : diff[l];
      nmag[l] = m[DW-1:0];
      side_nxt.neg[l] = diff[l][DW] ^ dir[l][DW-1];
    end
    dxm   = in_ray.dir_x[DW-1] ? (DW+1)'(-(DW+1)'(in_ray.dir_x)) : (DW+1)'(in_ray.dir_x);
    dym   = in_ray.dir_y[DW-1] ? (DW+1)'(-(DW+1)'(in_ray.dir_y)) : (DW+1)'(in_ray.dir_y);
    par_x = (in_ray.dir_x == '0) || (dxm < (DW+1)'(thr_r));
    par_y = (in_ray.dir_y == '0) || (dym < (DW+1)'(thr_r));
    ok_x  = !((in_ray.origin_x < in_ray.box_left) || (in_ray.box_right < in_ray.origin_x));
    ok_y  = !((in_ray.origin_y < in_ray.box_top) || (in_ray.box_bottom < in_ray.origin_y));
    side_nxt.par_x = par_x;
    side_nxt.par_y = par_y;
    side_nxt.ok_x  = ok_x;
    side_nxt.ok_y  = ok_y;
  end

  logic s0_v_r;
  logic [NW-1:0] s0_dq_r [LN];
  logic [DW-1:0] s0_den_r [LN];
  rayslab_pkg::side_t s0_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_ray.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LN; l++) begin
        s0_dq_r[l] <= {nmag[l], {FRAC_BITS{1'b0}}};
      end
      s0_den_r[rayslab_pkg::LN_X_LO] <= dxm[DW-1:0];
      s0_den_r[rayslab_pkg::LN_X_HI] <= dxm[DW-1:0];
      s0_den_r[rayslab_pkg::LN_Y_LO] <= dym[DW-1:0];
      s0_den_r[rayslab_pkg::LN_Y_HI] <= dym[DW-1:0];
      s0_side_r <= side_nxt;
    end
  end

  logic dv;
  logic [NW-1:0] quo [LN];
  rayslab_pkg::side_t dside;

  rayslab_div #(.NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s0_v_r),
    .in_dq    (s0_dq_r),
    .in_den   (s0_den_r),
    .in_side  (s0_side_r),
    .out_valid(dv),
    .out_quo  (quo),
    .out_side (dside)
  );

  logic signed [TW-1:0] tq [LN];
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      tq[l] = dside.neg[l] ? TW'(-$signed({1'b0, quo[l]})) : $signed({1'b0, quo[l]});
    end
  end

  // x axis stage
  logic signed [TW-1:0] xa_ent, xa_ext, xa_tmin_nxt, xa_tmax_nxt;
  logic xa_lo, xa_hit_nxt;
  logic signed [rayslab_pkg::NRM_W-1:0] xa_nx_nxt;

  always_comb begin
    if (tq[rayslab_pkg::LN_X_LO] <= tq[rayslab_pkg::LN_X_HI]) begin
      xa_ent = tq[rayslab_pkg::LN_X_LO];
      xa_ext = tq[rayslab_pkg::LN_X_HI];
      xa_lo  = 1'b1;
    end else begin
      xa_ent = tq[rayslab_pkg::LN_X_HI];
      xa_ext = tq[rayslab_pkg::LN_X_LO];
      xa_lo  = 1'b0;
    end
    if (dside.par_x) begin
      xa_tmin_nxt = '0;
      xa_tmax_nxt = T_INF;
      xa_hit_nxt  = dside.ok_x;
      xa_nx_nxt   = rayslab_pkg::NRM_NONE;
    end else begin
      xa_tmin_nxt = (xa_ent > 0) ? xa_ent : '0;
      xa_tmax_nxt = xa_ext;
      xa_hit_nxt  = xa_tmin_nxt <= xa_tmax_nxt;
      xa_nx_nxt   = (xa_ent > 0) ? (xa_lo ? rayslab_pkg::NRM_NEG : rayslab_pkg::NRM_POS)
                                 : rayslab_pkg::NRM_NONE;
    end
  end

  logic xa_v_r, xa_hit_r, xa_par_y_r, xa_ok_y_r;
  logic signed [TW-1:0] xa_tmin_r, xa_tmax_r, xa_ty1_r, xa_ty2_r;
  logic signed [rayslab_pkg::NRM_W-1:0] xa_nx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xa_v_r <= 1'b0;
    end else if (en) begin
      xa_v_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_hit_r   <= xa_hit_nxt;
      xa_tmin_r  <= xa_tmin_nxt;
      xa_tmax_r  <= xa_tmax_nxt;
      xa_nx_r    <= xa_nx_nxt;
      xa_ty1_r   <= tq[rayslab_pkg::LN_Y_LO];
      xa_ty2_r   <= tq[rayslab_pkg::LN_Y_HI];
      xa_par_y_r <= dside.par_y;
      xa_ok_y_r  <= dside.ok_y;
    end
  end

  // y axis stage and output register
  logic signed [TW-1:0] ya_ent, ya_ext, ya_tmin, ya_tmax;
  logic ya_lo, ya_hit;
  logic signed [rayslab_pkg::NRM_W-1:0] ya_nx, ya_ny;
  logic hit_nxt;
  logic [rayslab_pkg::DIST_W-1:0] dist_nxt;
  logic signed [rayslab_pkg::NRM_W-1:0] nx_nxt, ny_nxt;

  always_comb begin
    if (xa_ty1_r <= xa_ty2_r) begin
      ya_ent = xa_ty1_r;
      ya_ext = xa_ty2_r;
      ya_lo  = 1'b1;
    end else begin
      ya_ent = xa_ty2_r;
      ya_ext = xa_ty1_r;
      ya_lo  = 1'b0;
    end
    ya_tmin = xa_tmin_r;
    ya_tmax = xa_tmax_r;
    ya_nx   = xa_nx_r;
    ya_ny   = rayslab_pkg::NRM_NONE;
    if (xa_par_y_r) begin
      ya_hit = xa_ok_y_r;
    end else begin
      if (ya_ent > xa_tmin_r) begin
        ya_tmin = ya_ent;
        ya_nx   = rayslab_pkg::NRM_NONE;
        ya_ny   = ya_lo ? rayslab_pkg::NRM_NEG : rayslab_pkg::NRM_POS;
      end
      if (ya_ext < xa_tmax_r) begin
        ya_tmax = ya_ext;
      end
      ya_hit = ya_tmin <= ya_tmax;
    end
    hit_nxt = xa_hit_r && ya_hit;
    if (hit_nxt) begin
      dist_nxt = (ya_tmin > D_MAX) ? D_MAX[rayslab_pkg::DIST_W-1:0]
                                   : ya_tmin[rayslab_pkg::DIST_W-1:0];
      nx_nxt   = ya_nx;
      ny_nxt   = ya_ny;
    end else begin
      dist_nxt = '0;
      nx_nxt   = rayslab_pkg::NRM_NONE;
      ny_nxt   = rayslab_pkg::NRM_NONE;
    end
  end

  logic out_v_r, hit_r;
  logic [rayslab_pkg::DIST_W-1:0] dist_r;
  logic signed [rayslab_pkg::NRM_W-1:0] nx_r, ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= xa_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
      nx_r   <= nx_nxt;
      ny_r   <= ny_nxt;
    end
  end

  // pipeline advances unless a finished result is held at the output
  assign en = !out_v_r || out_res.ready;

  assign in_ray.ready     = en;
  assign out_res.valid    = out_v_r;
  assign out_res.hit      = hit_r;
  assign out_res.distance = dist_r;
  assign out_res.normal_x = nx_r;
  assign out_res.normal_y = ny_r;

endmodule
